// ===== hdl/scp_pkg.sv =====
// Shared types, constants and fixed-point helpers of the S-curve profile generator.
`default_nettype none
package scp_pkg;

    // Q16.16 value format.
    localparam int VW = 32;
    localparam int FB = 16;

    typedef logic signed [VW-1:0] t_val;
    typedef logic [VW-2:0]        t_lim;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW+1:0] WMAX = {2'b00, VMAX};
    localparam logic signed [VW+1:0] WMIN = {2'b11, VMIN};
    localparam logic [63:0] MAGMAX = {{(64-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [63:0] MAGNEG = MAGMAX + 64'd1;
    localparam logic [63:0] RECIP3 = 64'h0000_0000_AAAA_AAAB;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FB - 1);

    // Configuration register indexes.
    typedef logic [2:0] t_cidx;
    localparam t_cidx CFG_START = 3'd0;
    localparam t_cidx CFG_END   = 3'd1;
    localparam t_cidx CFG_VEL   = 3'd2;
    localparam t_cidx CFG_ACC   = 3'd3;
    localparam t_cidx CFG_JERK  = 3'd4;

    // Segment codes outside the seven profile segments.
    localparam logic [3:0] SEG_PRE = 4'd0;
    localparam logic [3:0] SEG_END = 4'd8;

    // Operations of the iterative unit.
    typedef enum logic [1:0] {OP_DIV, OP_SQRT, OP_CBRT} t_op;

    typedef struct packed {
        t_val start_pos;
        t_val end_pos;
        t_lim vel;
        t_lim acc;
        t_lim jrk;
    } t_cfg;

    typedef struct packed {
        logic           invalid;
        logic           negative;
        t_val [6:0]     bt;
        t_val [5:0]     kp;
        t_val [5:0]     kv;
        t_val [1:0]     ka;
        t_val           jh;
        t_val           jt;
    } t_plan;

    // One word entering the sample pipeline.
    typedef struct packed {
        logic       vld;
        logic       knot;
        logic [2:0] seg;
        t_val       tm;
    } t_item;

    // Raw cubic end state returned to the planner.
    typedef struct packed {
        logic vld;
        t_val p;
        t_val v;
        t_val a;
    } t_kres;

    function automatic t_val f_sat(input logic signed [VW+1:0] x);
        if (x > WMAX) return VMAX;
        if (x < WMIN) return VMIN;
        return x[VW-1:0];
    endfunction

    function automatic t_val f_add(input t_val a, input t_val b);
        return f_sat({{2{a[VW-1]}}, a} + {{2{b[VW-1]}}, b});
    endfunction

    function automatic t_val f_sub(input t_val a, input t_val b);
        return f_sat({{2{a[VW-1]}}, a} - {{2{b[VW-1]}}, b});
    endfunction

    function automatic t_val f_neg(input t_val a);
        return f_sat(-{{2{a[VW-1]}}, a});
    endfunction

    function automatic logic [VW-1:0] f_mag(input t_val x);
        return x[VW-1] ? (~x + 1'b1) : x;
    endfunction

    // Signed result from a magnitude, saturated.
    function automatic t_val f_from_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > MAGNEG) return VMIN;
            return ~m[VW-1:0] + 1'b1;
        end
        if (m > MAGMAX) return VMAX;
        return m[VW-1:0];
    endfunction

    // Rounded Q16.16 product, ties away from zero.
    function automatic t_val f_mul(input t_val a, input t_val b);
        logic [63:0] p;
        p = 64'(f_mag(a)) * 64'(f_mag(b));
        p = (p + HALF_LSB) >> FB;
        return f_from_mag(p, a[VW-1] ^ b[VW-1]);
    endfunction

    function automatic t_val f_half(input t_val x);
        logic [63:0] m;
        m = 64'(f_mag(x)) + 64'd1;
        return f_from_mag(m >> 1, x[VW-1]);
    endfunction

    // Rounded division by three through a reciprocal multiply.
    function automatic t_val f_third(input t_val x);
        logic [63:0] m;
        logic [63:0] q;
        m = 64'(f_mag(x)) + 64'd1;
        q = (m * RECIP3) >> 33;
        return f_from_mag(q, x[VW-1]);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/scp_iter.sv =====
// Shared iterative unit: rounded divide, square root and cube root.
`default_nettype none
module scp_iter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_abort,
    input  wire logic         i_go,
    input  wire scp_pkg::t_op i_op,
    input  wire scp_pkg::t_val i_a,
    input  wire scp_pkg::t_val i_b,
    output logic              o_done,
    output scp_pkg::t_val     o_res
);
    import scp_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    t_op         r_op;
    logic [65:0] r_num;
    logic [47:0] r_rem;
    logic [63:0] r_y;
    logic [31:0] r_d;
    logic        r_neg;
    logic        r_special;
    t_val        r_sval;

    logic [63:0] w_n;
    logic [32:0] w_drem;
    logic        w_dge;
    logic [47:0] w_srem;
    logic [47:0] w_strial;
    logic        w_sge;
    logic [47:0] w_crem;
    logic [23:0] w_cy;
    logic [47:0] w_cb;
    logic        w_cge;

    // One step of each recurrence.
    always_comb begin
        w_n      = {16'd0, f_mag(i_a), 16'd0} + 64'(f_mag(i_b) >> 1);
        w_drem   = {r_rem[31:0], r_num[65]};
        w_dge    = w_drem >= {1'b0, r_d};
        w_srem   = {r_rem[45:0], r_num[65:64]};
        w_strial = {r_y[45:0], 2'b01};
        w_sge    = w_srem >= w_strial;
        w_crem   = {r_rem[44:0], r_num[65:63]};
        w_cy     = {r_y[22:0], 1'b0};
        w_cb     = 48'd3 * (48'(w_cy) * (48'(w_cy) + 48'd1)) + 48'd1;
        w_cge    = w_crem >= w_cb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_abort) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else if (i_go) begin
            r_busy    <= 1'b1;
            o_done    <= 1'b0;
            r_op      <= i_op;
            r_rem     <= '0;
            r_y       <= '0;
            r_d       <= f_mag(i_b);
            r_special <= 1'b0;
            r_sval    <= '0;
            unique case (i_op)
                OP_DIV: begin
                    r_num <= {w_n[48:0], 17'd0};
                    r_cnt <= 6'd49;
                    r_neg <= i_a[VW-1] ^ i_b[VW-1];
                    if (i_b == '0) begin
                        r_special <= 1'b1;
                        r_cnt     <= 6'd0;
                        r_sval    <= (i_a == '0) ? '0 : (i_a[VW-1] ? VMIN : VMAX);
                    end
                end
                OP_SQRT: begin
                    r_num <= {i_a, 16'd0, 18'd0};
                    r_cnt <= 6'd24;
                    r_neg <= 1'b0;
                    if (i_a[VW-1] || i_a == '0) begin
                        r_special <= 1'b1;
                        r_cnt     <= 6'd0;
                    end
                end
                OP_CBRT: begin
                    r_num <= {2'b00, f_mag(i_a), 32'd0};
                    r_cnt <= 6'd22;
                    r_neg <= i_a[VW-1];
                end
                default: begin
                    r_num <= '0;
                    r_cnt <= 6'd0;
                    r_neg <= 1'b0;
                end
            endcase
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
                o_res  <= r_special ? r_sval : f_from_mag(r_y, r_neg);
            end else begin
                r_cnt <= r_cnt - 6'd1;
                case (r_op)
                    OP_DIV: begin
                        r_rem <= 48'(w_dge ? w_drem - {1'b0, r_d} : w_drem);
                        r_y   <= {r_y[62:0], w_dge};
                        r_num <= {r_num[64:0], 1'b0};
                    end
                    OP_SQRT: begin
                        r_rem <= w_sge ? w_srem - w_strial : w_srem;
                        r_y   <= {r_y[62:0], w_sge};
                        r_num <= {r_num[63:0], 2'b00};
                    end
                    default: begin
                        r_rem <= w_cge ? w_crem - w_cb : w_crem;
                        r_y   <= 64'(w_cy) + 64'(w_cge);
                        r_num <= {r_num[62:0], 3'b000};
                    end
                endcase
            end
        end else begin
            o_done <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scp_plan.sv =====
// Move planner: segment times by the four classic cases, then the knot states.
`default_nettype none
module scp_plan (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_restart,
    input  wire scp_pkg::t_cfg  i_cfg,
    input  wire scp_pkg::t_kres i_kres,
    output logic                o_busy,
    output scp_pkg::t_plan      o_plan,
    output scp_pkg::t_item      o_kreq
);
    import scp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_VA, ST_T1, ST_SA, ST_Q, ST_T2, ST_SQ, ST_MVJ, ST_SVC,
        ST_SVD, ST_SVE, ST_CASE, ST_TVS, ST_CB, ST_CBR, ST_TA1, ST_U2, ST_U3,
        ST_U4, ST_U5, ST_U6, ST_BT, ST_KN, ST_KW, ST_WAIT
    } t_state;

    t_state r_state;
    t_state r_ret;
    logic   r_go;
    t_op    r_op;
    t_val   r_ia;
    t_val   r_ib;
    t_val   r_s;
    t_val   r_a2;
    t_val   r_va;
    t_val   r_sa;
    t_val   r_q;
    t_val   r_sq;
    t_val   r_m;
    t_val   r_sv;
    t_val   r_t;
    t_val   r_tj;
    t_val   r_ta;
    t_val   r_tv;
    logic [2:0] r_k;

    logic w_done;
    t_val w_res;
    t_val w_v;
    t_val w_a;
    t_val w_j;
    t_val w_diff;
    logic w_short;

    scp_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_abort (i_restart),
        .i_go    (r_go),
        .i_op    (r_op),
        .i_a     (r_ia),
        .i_b     (r_ib),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Limits as values and the move distance.
    always_comb begin
        w_v = {1'b0, i_cfg.vel};
        w_a = {1'b0, i_cfg.acc};
        w_j = {1'b0, i_cfg.jrk};
        if (i_cfg.start_pos > i_cfg.end_pos) begin
            w_diff = f_sub(i_cfg.start_pos, i_cfg.end_pos);
        end else begin
            w_diff = f_sub(i_cfg.end_pos, i_cfg.start_pos);
        end
        // Case choice needs the cube-root form when the distance is short.
        w_short = (w_v >= r_va) && (r_s <= r_sa);
    end

    assign o_busy = (r_state != ST_IDLE);

    // Planning sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_go       <= 1'b0;
            o_kreq.vld <= 1'b0;
        end else if (i_restart) begin
            r_state    <= ST_INIT;
            r_go       <= 1'b0;
            o_kreq.vld <= 1'b0;
        end else begin
            r_go       <= 1'b0;
            o_kreq.vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_INIT: begin
                    o_plan.invalid  <= (w_v == '0) || (w_a == '0) || (w_j == '0);
                    o_plan.negative <= i_cfg.start_pos > i_cfg.end_pos;
                    r_s             <= w_diff;
                    r_a2            <= f_mul(w_a, w_a);
                    r_state <= ((w_v == '0) || (w_a == '0) || (w_j == '0)) ? ST_IDLE : ST_VA;
                end
                ST_VA: begin
                    r_go <= 1'b1; r_op <= OP_DIV; r_ia <= r_a2; r_ib <= w_j;
                    r_ret <= ST_T1; r_state <= ST_WAIT;
                end
                ST_T1: begin
                    r_va    <= w_res;
                    r_t     <= f_mul(f_add(w_res, w_res), w_a);
                    r_state <= ST_SA;
                end
                ST_SA: begin
                    r_go <= 1'b1; r_op <= OP_DIV; r_ia <= r_t; r_ib <= w_j;
                    r_ret <= ST_Q; r_state <= ST_WAIT;
                end
                ST_Q: begin
                    r_sa <= w_res;
                    r_go <= 1'b1; r_op <= OP_DIV; r_ia <= w_a; r_ib <= w_j;
                    r_ret <= ST_T2; r_state <= ST_WAIT;
                end
                ST_T2: begin
                    r_q  <= w_res;
                    r_go <= 1'b1; r_op <= OP_DIV; r_ia <= w_v; r_ib <= w_j;
                    r_ret <= ST_SQ; r_state <= ST_WAIT;
                end
                ST_SQ: begin
                    r_go <= 1'b1; r_op <= OP_SQRT; r_ia <= w_res; r_ib <= w_j;
                    r_ret <= ST_MVJ; r_state <= ST_WAIT;
                end
                ST_MVJ: begin
                    r_sq    <= w_res;
                    r_m     <= f_mul(w_v, w_j);
                    r_state <= ST_SVC;
                end
                // Distance that reaches the velocity limit.
                ST_SVC: begin
                    if (r_m < r_a2) begin
                        r_sv    <= f_mul(f_add(w_v, w_v), r_sq);
                        r_state <= ST_CASE;
                    end else begin
                        r_go <= 1'b1; r_op <= OP_DIV; r_ia <= w_v; r_ib <= w_a;
                        r_ret <= ST_SVD; r_state <= ST_WAIT;
                    end
                end
                ST_SVD: begin
                    r_t     <= f_add(w_res, r_q);
                    r_state <= ST_SVE;
                end
                ST_SVE: begin
                    r_sv    <= f_mul(w_v, r_t);
                    r_state <= ST_CASE;
                end
                // Pick one of the four cases.
                ST_CASE: begin
                    if (((w_v <= r_va) && (r_s >= r_sa))
                        || ((w_v <= r_va) && !w_short && (r_s >= r_sv))) begin
                        r_tj <= r_sq; r_ta <= r_sq;
                        r_go <= 1'b1; r_op <= OP_DIV; r_ia <= r_s; r_ib <= w_v;
                        r_ret <= ST_TVS; r_state <= ST_WAIT;
                    end else if (w_short || (w_v <= r_va)) begin
                        r_go <= 1'b1; r_op <= OP_DIV; r_ia <= r_s; r_ib <= f_add(w_j, w_j);
                        r_ret <= ST_CB; r_state <= ST_WAIT;
                    end else if (r_s >= r_sv) begin
                        r_tj <= r_q;
                        r_go <= 1'b1; r_op <= OP_DIV; r_ia <= w_v; r_ib <= w_a;
                        r_ret <= ST_TA1; r_state <= ST_WAIT;
                    end else begin
                        r_tj    <= r_q;
                        r_t     <= f_mul(w_a, r_q);
                        r_state <= ST_U2;
                    end
                end
                ST_TVS: begin
                    r_tv    <= w_res;
                    r_state <= ST_BT;
                end
                ST_CB: begin
                    r_go <= 1'b1; r_op <= OP_CBRT; r_ia <= w_res; r_ib <= w_j;
                    r_ret <= ST_CBR; r_state <= ST_WAIT;
                end
                ST_CBR: begin
                    r_tj    <= w_res;
                    r_ta    <= w_res;
                    r_tv    <= f_add(w_res, w_res);
                    r_state <= ST_BT;
                end
                ST_TA1: begin
                    r_ta <= w_res;
                    r_go <= 1'b1; r_op <= OP_DIV; r_ia <= r_s; r_ib <= w_v;
                    r_ret <= ST_TVS; r_state <= ST_WAIT;
                end
                ST_U2: begin
                    r_t     <= f_mul(r_t, r_q);
                    r_state <= ST_U3;
                end
                ST_U3: begin
                    r_go <= 1'b1; r_op <= OP_DIV;
                    r_ia <= f_add(f_add(f_add(r_s, r_s), f_add(r_s, r_s)), r_t);
                    r_ib <= w_a;
                    r_ret <= ST_U4; r_state <= ST_WAIT;
                end
                ST_U4: begin
                    r_go <= 1'b1; r_op <= OP_SQRT; r_ia <= w_res; r_ib <= w_a;
                    r_ret <= ST_U5; r_state <= ST_WAIT;
                end
                ST_U5: begin
                    r_ta    <= f_half(f_sub(w_res, r_q));
                    r_state <= ST_U6;
                end
                ST_U6: begin
                    r_tv    <= f_add(r_ta, r_tj);
                    r_state <= ST_BT;
                end
                // Segment boundary times and the halved and third jerk.
                ST_BT: begin
                    o_plan.bt[0] <= r_tj;
                    o_plan.bt[1] <= r_ta;
                    o_plan.bt[2] <= f_add(r_ta, r_tj);
                    o_plan.bt[3] <= r_tv;
                    o_plan.bt[4] <= f_add(r_tv, r_tj);
                    o_plan.bt[5] <= f_add(r_tv, r_ta);
                    o_plan.bt[6] <= f_add(f_add(r_tv, r_tj), r_ta);
                    o_plan.jh    <= f_half(w_j);
                    o_plan.jt    <= f_third(w_j);
                    r_k          <= 3'd1;
                    r_state      <= ST_KN;
                end
                // Knots are evaluated by the sample pipeline, one segment at a time.
                ST_KN: begin
                    o_kreq.vld  <= 1'b1;
                    o_kreq.knot <= 1'b1;
                    o_kreq.seg  <= r_k;
                    o_kreq.tm   <= o_plan.bt[3'(r_k - 3'd1)];
                    r_state     <= ST_KW;
                end
                ST_KW: begin
                    if (i_kres.vld) begin
                        o_plan.kp[3'(r_k - 3'd1)] <= i_kres.p;
                        o_plan.kv[3'(r_k - 3'd1)] <= i_kres.v;
                        if (r_k == 3'd1) o_plan.ka[0] <= i_kres.a;
                        if (r_k == 3'd5) o_plan.ka[1] <= i_kres.a;
                        if (r_k == 3'd6) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= ST_KN;
                        end
                    end
                end
                ST_WAIT: begin
                    if (w_done) r_state <= r_ret;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scp_pipe.sv =====
// Sample pipeline: segment search, cubic evaluation and output formatting.
`default_nettype none
module scp_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire scp_pkg::t_item i_item,
    input  wire scp_pkg::t_plan i_plan,
    input  wire scp_pkg::t_cfg  i_cfg,
    output logic                o_valid,
    output scp_pkg::t_val       o_position,
    output scp_pkg::t_val       o_velocity,
    output scp_pkg::t_val       o_acceleration,
    output scp_pkg::t_val       o_jerk,
    output logic [3:0]          o_segment,
    output logic                o_plan_invalid,
    output scp_pkg::t_kres      o_kres
);
    import scp_pkg::*;

    // Valid bits and flags that travel with each word.
    logic [8:1] r_vld;
    logic [8:1] r_knot;
    logic [8:1] r_pre;
    logic [8:1] r_fin;
    logic [3:0] r_seg [1:8];
    t_val       r_j   [2:8];
    t_val       r_dt  [2:6];
    t_val       r_p0  [2:7];
    t_val       r_v0  [2:5];
    t_val       r_a0  [2:3];

    t_val r1_t;
    t_val r2_jh, r2_jt;
    t_val r3_m1, r3_m2, r3_m3;
    t_val r4_a, r4_x2, r4_x3;
    t_val r5_a, r5_m4, r5_m5;
    t_val r6_a, r6_v, r6_y;
    t_val r7_a, r7_v, r7_m6;
    t_val r8_a, r8_v, r8_p;

    logic [3:0] w_k;
    logic       w_pre;
    t_val       w_jm;
    t_val       w_t0, w_p0, w_v0, w_a0, w_j, w_jh, w_jt;
    logic [2:0] w_idx;
    t_val       w_pn;

    assign w_jm = {1'b0, i_cfg.jrk};

    // Stage 1: find the segment, first boundary not yet reached.
    always_comb begin
        w_pre = i_item.tm[VW-1] && !i_item.knot;
        w_k   = SEG_END;
        for (int i = 6; i >= 0; i--) begin
            if (i_item.tm < i_plan.bt[i]) w_k = 4'(i + 1);
        end
        if (i_item.knot) w_k = {1'b0, i_item.seg};
        if (w_pre) w_k = SEG_PRE;
    end

    // Stage 2 selection: start state and jerk of the segment.
    always_comb begin
        w_idx = 3'(r_seg[1] - 4'd2);
        w_t0 = '0; w_p0 = '0; w_v0 = '0; w_a0 = '0;
        w_j = '0; w_jh = '0; w_jt = '0;
        if (r_seg[1] >= 4'd2 && r_seg[1] <= 4'd7) begin
            w_t0 = i_plan.bt[w_idx];
            w_p0 = i_plan.kp[w_idx];
            w_v0 = i_plan.kv[w_idx];
        end
        case (r_seg[1])
            4'd1: begin
                w_j = w_jm; w_jh = i_plan.jh; w_jt = i_plan.jt;
            end
            4'd2: w_a0 = i_plan.ka[0];
            4'd3: begin
                w_a0 = i_plan.ka[0];
                w_j = -w_jm; w_jh = -i_plan.jh; w_jt = -i_plan.jt;
            end
            4'd5: begin
                w_j = -w_jm; w_jh = -i_plan.jh; w_jt = -i_plan.jt;
            end
            4'd6: w_a0 = i_plan.ka[1];
            4'd7: begin
                w_a0 = i_plan.ka[1];
                w_j = w_jm; w_jh = i_plan.jh; w_jt = i_plan.jt;
            end
            default: ;
        endcase
    end

    // Valid bit shift line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:1], i_item.vld};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        r_knot <= {r_knot[7:1], i_item.knot};
        r_pre  <= {r_pre[7:1], w_pre};
        r_fin  <= {r_fin[7:1], (w_k == SEG_END)};
        r_seg[1] <= w_k;
        for (int s = 2; s <= 8; s++) r_seg[s] <= r_seg[s-1];
        r1_t <= i_item.tm;

        r_dt[2] <= f_sub(r1_t, w_t0);
        r_p0[2] <= w_p0;
        r_v0[2] <= w_v0;
        r_a0[2] <= w_a0;
        r_j[2]  <= w_j;
        r2_jh   <= w_jh;
        r2_jt   <= w_jt;
        for (int s = 3; s <= 6; s++) r_dt[s] <= r_dt[s-1];
        for (int s = 3; s <= 7; s++) r_p0[s] <= r_p0[s-1];
        for (int s = 3; s <= 5; s++) r_v0[s] <= r_v0[s-1];
        r_a0[3] <= r_a0[2];
        for (int s = 3; s <= 8; s++) r_j[s]  <= r_j[s-1];

        r3_m1 <= f_mul(r_j[2], r_dt[2]);
        r3_m2 <= f_mul(r2_jh, r_dt[2]);
        r3_m3 <= f_mul(r2_jt, r_dt[2]);

        r4_a  <= f_add(r_a0[3], r3_m1);
        r4_x2 <= f_add(r_a0[3], r3_m2);
        r4_x3 <= f_half(f_add(r_a0[3], r3_m3));

        r5_a  <= r4_a;
        r5_m4 <= f_mul(r4_x2, r_dt[4]);
        r5_m5 <= f_mul(r4_x3, r_dt[4]);

        r6_a <= r5_a;
        r6_v <= f_add(r_v0[5], r5_m4);
        r6_y <= f_add(r_v0[5], r5_m5);

        r7_a  <= r6_a;
        r7_v  <= r6_v;
        r7_m6 <= f_mul(r6_y, r_dt[6]);

        r8_a <= r7_a;
        r8_v <= r7_v;
        r8_p <= f_add(r_p0[7], r7_m6);
    end

    assign o_kres.vld = r_vld[8] && r_knot[8];
    assign o_kres.p   = r8_p;
    assign o_kres.v   = r8_v;
    assign o_kres.a   = r8_a;

    assign w_pn = i_plan.negative ? f_neg(r8_p) : r8_p;

    // Output register: direction, start offset and the special cases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[8] && !r_knot[8];
        end
        o_plan_invalid <= i_plan.invalid;
        o_velocity     <= '0;
        o_acceleration <= '0;
        o_jerk         <= '0;
        o_segment      <= r_seg[8];
        if (i_plan.invalid) begin
            o_position <= '0;
            o_segment  <= SEG_PRE;
        end else if (r_pre[8]) begin
            o_position <= i_cfg.start_pos;
        end else if (r_fin[8]) begin
            o_position <= i_cfg.end_pos;
        end else begin
            o_position     <= f_add(i_cfg.start_pos, w_pn);
            o_velocity     <= i_plan.negative ? f_neg(r8_v) : r8_v;
            o_acceleration <= i_plan.negative ? f_neg(r8_a) : r8_a;
            o_jerk         <= i_plan.negative ? f_neg(r_j[8]) : r_j[8];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/s_curve_motion_profile.sv =====
// Top level of the jerk-limited seven-segment S-curve profile generator.
//
// After reset and after every write to a known register the block plans the move
// and holds o_busy high meanwhile; planning runs the shared divide, square-root
// and cube-root unit and then six knot evaluations through the sample pipeline.
// Once o_busy is low, one time sample may be issued on i_start in every cycle.
// Each result word appears on the outputs, marked by o_valid for one cycle, once
// its sample has passed the pipeline and the output register, in issue order;
// the receiver must take it then.
`default_nettype none
module s_curve_motion_profile (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire scp_pkg::t_val i_sample_time,
    output logic               o_valid,
    output scp_pkg::t_val      o_position,
    output scp_pkg::t_val      o_velocity,
    output scp_pkg::t_val      o_acceleration,
    output scp_pkg::t_val      o_jerk,
    output logic [3:0]         o_segment,
    output logic               o_plan_invalid
);
    import scp_pkg::*;

    t_cfg  r_cfg;
    logic  r_restart;
    t_plan w_plan;
    t_item w_kreq;
    t_item w_item;
    t_kres w_kres;

    // Configuration registers; any write to a known register replans.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START: begin r_cfg.start_pos <= i_cfg_data; r_restart <= 1'b1; end
                    CFG_END:   begin r_cfg.end_pos   <= i_cfg_data; r_restart <= 1'b1; end
                    CFG_VEL:   begin r_cfg.vel <= i_cfg_data[30:0]; r_restart <= 1'b1; end
                    CFG_ACC:   begin r_cfg.acc <= i_cfg_data[30:0]; r_restart <= 1'b1; end
                    CFG_JERK:  begin r_cfg.jrk <= i_cfg_data[30:0]; r_restart <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    scp_plan u_plan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (r_restart || (i_cfg_we && (i_cfg_index <= CFG_JERK))),
        .i_cfg     (r_cfg),
        .i_kres    (w_kres),
        .o_busy    (o_busy),
        .o_plan    (w_plan),
        .o_kreq    (w_kreq)
    );

    // Knot requests and samples never meet: samples are not taken while planning.
    always_comb begin
        if (w_kreq.vld) begin
            w_item = w_kreq;
        end else begin
            w_item.vld  = i_start && !o_busy;
            w_item.knot = 1'b0;
            w_item.seg  = '0;
            w_item.tm   = i_sample_time;
        end
    end

    scp_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_item),
        .i_plan         (w_plan),
        .i_cfg          (r_cfg),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_jerk         (o_jerk),
        .o_segment      (o_segment),
        .o_plan_invalid (o_plan_invalid),
        .o_kres         (w_kres)
    );

`ifndef NO_ASSERTIONS
    // Every result word comes from an accepted sample.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 9))
        else $error("result word without a matching sample");

    // Segment codes stay within the documented range.
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_segment <= SEG_END))
        else $error("segment code out of range");

    // Outside the moving segments the block reports rest.
    a_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_segment == SEG_PRE || o_segment == SEG_END))
        |-> (o_velocity == '0 && o_acceleration == '0 && o_jerk == '0))
        else $error("motion reported outside the profile");

    // An invalid plan forces a zero result.
    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_plan_invalid) |-> (o_position == '0 && o_segment == SEG_PRE))
        else $error("invalid plan with nonzero result");
`endif

endmodule
`default_nettype wire

// ===== tb/s_curve_motion_profile_tb.sv =====
// Self-checking testbench of the S-curve profile generator with its own profile predictor.
`timescale 1ns / 1ps
module s_curve_motion_profile_tb;
    import scp_pkg::*;

    // Predictor arithmetic runs on 64-bit values held to the 32-bit range.
    localparam longint QMAX = 64'sh7FFF_FFFF;
    localparam longint QMIN = -64'sh8000_0000;
    localparam logic [2:0] CFG_UNUSED = 3'd5;
    localparam int RESULT_LATENCY = 9;

    typedef struct {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] acceleration;
        logic [31:0] jerk;
        logic [3:0]  segment;
        logic        plan_invalid;
    } t_profile_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    t_val        i_sample_time;
    logic        o_valid;
    t_val        o_position;
    t_val        o_velocity;
    t_val        o_acceleration;
    t_val        o_jerk;
    logic [3:0]  o_segment;
    logic        o_plan_invalid;

    s_curve_motion_profile i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_sample_time  (i_sample_time),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_jerk         (o_jerk),
        .o_segment      (o_segment),
        .o_plan_invalid (o_plan_invalid)
    );

    // Predictor copy of the registers and of the planned move.
    longint reg_start, reg_end, reg_vel, reg_acc, reg_jerk;
    longint seg_bound[7];
    longint knot_pos[6];
    longint knot_vel[6];
    longint knot_acc[2];
    bit     plan_ready;
    bit     plan_bad;
    bit     move_negative;
    int     jerk_sign[8] = '{0, 1, 0, -1, 0, -1, 0, 1};

    t_profile_word pending_words[$];
    int  mismatches;
    int  words_checked;
    int  samples_sent;
    int  config_writes;
    bit  timed_out;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint q_sat(longint x);
        return x > QMAX ? QMAX : (x < QMIN ? QMIN : x);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return q_sat(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return q_sat(a - b);
    endfunction

    function automatic longint unsigned q_mag(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function automatic longint q_from_mag(longint unsigned m, bit neg);
        longint v;
        if (m > (64'd1 << 62)) m = 64'd1 << 62;
        v = longint'(m);
        return q_sat(neg ? -v : v);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint unsigned p;
        p = q_mag(a) * q_mag(b);
        p = (p + 64'd32768) >> 16;
        return q_from_mag(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint unsigned d, n;
        d = q_mag(b);
        n = q_mag(a) << 16;
        if (d == 0) return a == 0 ? 0 : (a > 0 ? QMAX : QMIN);
        return q_from_mag((n + d / 2) / d, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_div_const(longint a, longint unsigned k);
        return q_from_mag((q_mag(a) + k / 2) / k, a < 0);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned floor_cbrt(longint unsigned x);
        longint unsigned y, b;
        y = 0;
        for (int s = 63; s >= 0; s -= 3) begin
            y <<= 1;
            b = 3 * y * (y + 1) + 1;
            if ((x >> s) >= b) begin
                x -= b << s;
                y++;
            end
        end
        return y;
    endfunction

    function automatic longint q_sqrt(longint x);
        if (x <= 0) return 0;
        return q_from_mag(floor_sqrt(longint'(x) << 16), 1'b0);
    endfunction

    function automatic longint q_cbrt(longint x);
        return q_from_mag(floor_cbrt(q_mag(x) << 32), x < 0);
    endfunction

    // State at the end of a constant-jerk stretch of length dt.
    task automatic cubic_step(input longint p0, input longint v0, input longint a0,
                              input longint j, input longint dt,
                              output longint p, output longint v, output longint a);
        a = q_add(a0, q_mul(j, dt));
        v = q_add(v0, q_mul(q_add(a0, q_mul(q_div_const(j, 2), dt)), dt));
        p = q_add(p0, q_mul(q_add(v0, q_mul(q_div_const(q_add(a0,
                q_mul(q_div_const(j, 3), dt)), 2), dt)), dt));
    endtask

    function automatic longint segment_accel(int k);
        if (k == 2 || k == 3) return knot_acc[0];
        if (k == 6 || k == 7) return knot_acc[1];
        return 0;
    endfunction

    // Segment times and knot states of the current move.
    task automatic plan_move();
        longint move_dist, a2, va, sa, q, sq, sv, tj, ta, tv, p, v, a, t0, dt;
        p = 0;
        v = 0;
        a = 0;
        t0 = 0;
        seg_bound = '{default: 0};
        knot_pos = '{default: 0};
        knot_vel = '{default: 0};
        knot_acc = '{default: 0};
        plan_ready = 1'b1;
        move_negative = reg_start > reg_end;
        plan_bad = (reg_vel == 0 || reg_acc == 0 || reg_jerk == 0);
        if (plan_bad) return;
        move_dist = q_sat(move_negative ? reg_start - reg_end : reg_end - reg_start);
        a2 = q_mul(reg_acc, reg_acc);
        va = q_div(a2, reg_jerk);
        sa = q_div(q_mul(q_sat(2 * va), reg_acc), reg_jerk);
        q = q_div(reg_acc, reg_jerk);
        sq = q_sqrt(q_div(reg_vel, reg_jerk));
        if (q_mul(reg_vel, reg_jerk) < a2) sv = q_mul(q_sat(2 * reg_vel), sq);
        else sv = q_mul(reg_vel, q_add(q_div(reg_vel, reg_acc), q));

        // Pick the profile shape from the limits and the distance.
        if (reg_vel <= va && move_dist >= sa) begin
            tj = sq; ta = tj; tv = q_div(move_dist, reg_vel);
        end else if (reg_vel >= va && move_dist <= sa) begin
            tj = q_cbrt(q_div(move_dist, q_sat(2 * reg_jerk))); ta = tj; tv = q_sat(2 * tj);
        end else if (reg_vel <= va) begin
            if (move_dist >= sv) begin
                tj = sq; ta = tj; tv = q_div(move_dist, reg_vel);
            end else begin
                tj = q_cbrt(q_div(move_dist, q_sat(2 * reg_jerk)));
                ta = tj;
                tv = q_sat(2 * tj);
            end
        end else begin
            tj = q;
            if (move_dist >= sv) begin
                ta = q_div(reg_vel, reg_acc);
                tv = q_div(move_dist, reg_vel);
            end else begin
                ta = q_div_const(q_sub(q_sqrt(q_div(q_add(q_sat(4 * move_dist),
                        q_mul(q_mul(reg_acc, q), q)), reg_acc)), q), 2);
                tv = q_add(ta, tj);
            end
        end

        seg_bound[0] = tj;
        seg_bound[1] = ta;
        seg_bound[2] = q_add(ta, tj);
        seg_bound[3] = tv;
        seg_bound[4] = q_add(tv, tj);
        seg_bound[5] = q_add(tv, ta);
        seg_bound[6] = q_add(q_add(tv, tj), ta);

        // Knots are the segment ends, chained from rest.
        for (int k = 1; k <= 6; k++) begin
            dt = q_sub(seg_bound[k-1], t0);
            cubic_step(p, v, segment_accel(k), reg_jerk * jerk_sign[k], dt, p, v, a);
            knot_pos[k-1] = p;
            knot_vel[k-1] = v;
            if (k == 1) knot_acc[0] = a;
            if (k == 5) knot_acc[1] = a;
            t0 = seg_bound[k-1];
        end
    endtask

    task automatic predict_word(input logic [31:0] t_raw, output t_profile_word w);
        longint t, pp, vv, aa, jj, t0, p0, v0;
        int k;
        t = longint'($signed(t_raw));
        pp = 0; vv = 0; aa = 0; jj = 0;
        k = 0;
        if (!plan_ready) plan_move();
        if (!plan_bad) begin
            if (t < 0) begin
                pp = reg_start;
            end else begin
                k = 1;
                while (k <= 7 && t >= seg_bound[k-1]) k++;
                if (k == 8) begin
                    pp = reg_end;
                end else begin
                    t0 = k == 1 ? 0 : seg_bound[k-2];
                    p0 = k == 1 ? 0 : knot_pos[k-2];
                    v0 = k == 1 ? 0 : knot_vel[k-2];
                    jj = reg_jerk * jerk_sign[k];
                    cubic_step(p0, v0, segment_accel(k), jj, q_sub(t, t0), pp, vv, aa);
                    if (move_negative) begin
                        pp = q_sat(-pp); vv = q_sat(-vv); aa = q_sat(-aa); jj = q_sat(-jj);
                    end
                    pp = q_add(reg_start, pp);
                end
            end
        end
        w.position = pp[31:0];
        w.velocity = vv[31:0];
        w.acceleration = aa[31:0];
        w.jerk = jj[31:0];
        w.segment = 4'(k);
        w.plan_invalid = plan_bad;
    endtask

    // Write one register while the block is idle and, for a known register, wait for the new plan.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        config_writes++;
        case (idx)
            CFG_START: reg_start = longint'($signed(data));
            CFG_END:   reg_end = longint'($signed(data));
            CFG_VEL:   reg_vel = longint'(data[30:0]);
            CFG_ACC:   reg_acc = longint'(data[30:0]);
            CFG_JERK:  reg_jerk = longint'(data[30:0]);
            default:   return;
        endcase
        plan_ready = 1'b0;
        repeat (3) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic load_move(input logic [31:0] p_start, input logic [31:0] p_end,
                             input logic [31:0] vel, input logic [31:0] acc,
                             input logic [31:0] jrk);
        write_register(CFG_START, p_start);
        write_register(CFG_END, p_end);
        write_register(CFG_VEL, vel);
        write_register(CFG_ACC, acc);
        write_register(CFG_JERK, jrk);
        if (!plan_ready) plan_move();
    endtask

    // Issue one time sample; called and returning at a falling edge.
    task automatic send_sample(input logic [31:0] t);
        t_profile_word w;
        i_start <= 1'b1;
        i_sample_time <= t;
        do @(posedge i_clk); while (o_busy);
        predict_word(t, w);
        pending_words.push_back(w);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY + 3) @(negedge i_clk);
    endtask

    // Times around every segment boundary of the current plan.
    task automatic sweep_boundaries();
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        for (int k = 0; k < 7; k++) begin
            send_sample(seg_bound[k][31:0]);
            send_sample(32'(seg_bound[k] - 1));
        end
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    task automatic test_reset_invalid();
        send_sample(32'h0000_0000);
        send_sample(32'h0001_0000);
        drain_results();
    endtask

    task automatic test_directed_profile();
        load_move(32'h0000_0000, 32'h000A_0000, 32'h0002_0000, 32'h0001_0000,
                  32'h0001_0000);
        sweep_boundaries();
        drain_results();
    endtask

    task automatic test_extreme_moves();
        // Full-range negative move at the largest limits.
        load_move(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h7FFF_FFFF);
        drain_results();
        // Very short move at the smallest limits.
        load_move(32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                  32'h0000_0001);
        send_sample(32'h0000_0000);
        send_sample(32'(seg_bound[2]));
        drain_results();
        // An unused register index changes nothing.
        write_register(CFG_UNUSED, 32'hDEAD_BEEF);
        send_sample(32'h0000_8000);
        drain_results();
    endtask

    function automatic logic [31:0] random_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'h1;
        if (r == 2) return 32'h7FFF_FFFF;
        if (r == 3) return $urandom;
        return $urandom_range(32'h0000_1000, 32'h0100_0000);
    endfunction

    function automatic logic [31:0] random_time();
        int r;
        longint total;
        total = seg_bound[6];
        r = $urandom_range(0, 99);
        if (r < 6) return $urandom;
        if (r < 12) return -$urandom_range(1, 32'h0004_0000);
        if (r < 18) return 32'(q_add(total, $urandom_range(0, 32'h0004_0000)));
        return $urandom_range(0, 32'(total));
    endfunction

    task automatic test_random_moves();
        logic [31:0] p0, span;
        int burst;
        for (int phase = 0; phase < 16; phase++) begin
            p0 = $urandom;
            case ($urandom_range(0, 3))
                0: span = $urandom;
                1: span = $urandom_range(0, 32'h0000_FFFF);
                default: span = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            endcase
            if (phase == 0) load_move(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h0000_0001);
            else load_move(p0, p0 + span, random_limit(), random_limit(), random_limit());
            for (int n = 0; n < 100; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 100; b++, n++) send_sample(random_time());
                if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
            end
            drain_results();
        end
    endtask

    // Compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_profile_word w;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word at %0t", $time);
            end else begin
                w = pending_words.pop_front();
                words_checked++;
                if (o_position !== w.position || o_velocity !== w.velocity ||
                    o_acceleration !== w.acceleration || o_jerk !== w.jerk ||
                    o_segment !== w.segment || o_plan_invalid !== w.plan_invalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: exp p=%h v=%h a=%h j=%h s=%0d inv=%b, ",
                                 $time, w.position, w.velocity, w.acceleration, w.jerk,
                                 w.segment, w.plan_invalid,
                                 "got p=%h v=%h a=%h j=%h s=%0d inv=%b",
                                 o_position, o_velocity, o_acceleration, o_jerk,
                                 o_segment, o_plan_invalid);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_start = 1'b0;
        i_sample_time = '0;
        reg_start = 0; reg_end = 0; reg_vel = 0; reg_acc = 0; reg_jerk = 0;
        plan_ready = 1'b0;
        mismatches = 0;
        words_checked = 0;
        samples_sent = 0;
        config_writes = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_invalid();
        test_directed_profile();
        test_extreme_moves();
        test_random_moves();
        drain_results();

        $display("Run covered %0d time samples and %0d register writes; %0d words checked.",
                 samples_sent, config_writes, words_checked);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Guard against a stalled handshake.
    initial begin
        #4_000_000;
        $display("Timeout waiting for the block");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
